// File: design/bis_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint index search package
// Shared widths, register indexes and mode codes for the search block.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MaxEntries = 64;
  localparam int AddrW      = $clog2(MaxEntries);
  localparam int IdxW       = 7;
  localparam int ValW       = 32;
  localparam int ModeW      = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgW       = 7;

  localparam logic [ModeW-1:0] ModeSeq  = 2'd0;
  localparam logic [ModeW-1:0] ModeBin  = 2'd1;
  localparam logic [ModeW-1:0] ModeNear = 2'd2;

  localparam logic [CfgIdxW-1:0] CfgMode   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLength = 2'd1;

  localparam logic KindLoad   = 1'b0;
  localparam logic KindSearch = 1'b1;

  localparam logic [IdxW-1:0] MaxEntriesIdx = IdxW'(MaxEntries);

endpackage

// File: design/bis_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One address per cycle, for a write, a read whose data is registered, or both.
// ----------------------------------------------------------------------------
module bis_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

// File: design/breakpoint_index_search.sv
// ----------------------------------------------------------------------------
// Breakpoint index search
// Locates a query value in an ascending breakpoint table held in a RAM,
// by sequential scan, bisection or a walk from the last answer; mode 3 just repeats it.
// ----------------------------------------------------------------------------
// Load beats write the RAM at the accepting edge and leave the block idle.
// A search passes a dispatch state, then the search states of its mode,
// each step issuing one RAM read, then the result strobe. The single RAM
// port sets the pace.
// The receiver cannot stall; the result strobe overlaps the next accept.
// Reset returns to idle with binary mode, length 64 and previous index 0.
module breakpoint_index_search
  import bis_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind_i,
  input  logic [AddrW-1:0]      entry_position_i,
  input  logic signed [ValW-1:0] entry_value_i,
  input  logic signed [ValW-1:0] query_value_i,
  output logic                  result_valid_o,
  output logic [IdxW-1:0]       found_index_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgW-1:0]       cfg_wdata_i
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StDisp = 4'd1;
  localparam logic [3:0] StFwd  = 4'd2;
  localparam logic [3:0] StBack = 4'd3;
  localparam logic [3:0] StBin0 = 4'd4;
  localparam logic [3:0] StBin1 = 4'd5;
  localparam logic [3:0] StBmid = 4'd6;
  localparam logic [3:0] StNear0 = 4'd7;
  localparam logic [3:0] StNear1 = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [ModeW-1:0]      mode_q;
  logic [IdxW-1:0]       len_q;
  logic [IdxW-1:0]       prev_q, prev_d;
  logic [IdxW-1:0]       i_q, i_d;
  logic [IdxW-1:0]       lo_q, lo_d, hi_q, hi_d;
  logic signed [ValW-1:0] query_q;
  logic                  result_valid_q, result_valid_d;
  logic [IdxW-1:0]       found_q, found_d;
  logic [IdxW-1:0]       eff_n;
  logic                  accept;
  logic                  ram_we, ram_re;
  logic [AddrW-1:0]      ram_addr, rd_addr;
  logic signed [ValW-1:0] ram_rdata;

  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  // Length register keeps the written bits; the search clamps it to 1..max.
  always_comb begin
    if (len_q == '0) begin
      eff_n = IdxW'(1);
    end else if (len_q > MaxEntriesIdx) begin
      eff_n = MaxEntriesIdx;
    end else begin
      eff_n = len_q;
    end
  end

  assign ram_we   = accept && (kind_i == KindLoad);
  assign ram_addr = busy ? rd_addr : entry_position_i;

  bis_ram #(
    .Width (ValW),
    .Depth (MaxEntries)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (entry_value_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    logic [IdxW-1:0] step;
    logic [IdxW-1:0] nlo;
    logic [IdxW-1:0] nhi;
    logic            finish;
    logic [IdxW-1:0] answer;

    state_d        = state_q;
    i_d            = i_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    prev_d         = prev_q;
    found_d        = found_q;
    result_valid_d = 1'b0;
    ram_re         = 1'b0;
    rd_addr        = '0;
    finish         = 1'b0;
    answer         = '0;
    step           = '0;
    nlo            = lo_q;
    nhi            = hi_q;

    case (state_q)
      StIdle: begin
        if (accept && (kind_i == KindSearch)) begin
          state_d = StDisp;
        end
      end
      StDisp: begin
        case (mode_q)
          ModeSeq: begin
            ram_re  = 1'b1;
            rd_addr = '0;
            i_d     = '0;
            state_d = StFwd;
          end
          ModeBin: begin
            ram_re  = 1'b1;
            rd_addr = '0;
            state_d = StBin0;
          end
          ModeNear: begin
            if (prev_q >= eff_n) begin
              step    = eff_n - IdxW'(1);
              ram_re  = 1'b1;
              rd_addr = step[AddrW-1:0];
              i_d     = eff_n;
              state_d = StBack;
            end else if (prev_q == '0) begin
              ram_re  = 1'b1;
              rd_addr = '0;
              i_d     = '0;
              state_d = StFwd;
            end else begin
              ram_re  = 1'b1;
              rd_addr = prev_q[AddrW-1:0];
              state_d = StNear0;
            end
          end
          default: begin
            finish = 1'b1;
            answer = prev_q;
          end
        endcase
      end
      // RAM data holds the entry at i_q, which is below the length.
      StFwd: begin
        if (query_q > ram_rdata) begin
          step = i_q + IdxW'(1);
          if (step == eff_n) begin
            finish = 1'b1;
            answer = eff_n;
          end else begin
            ram_re  = 1'b1;
            rd_addr = step[AddrW-1:0];
            i_d     = step;
          end
        end else begin
          finish = 1'b1;
          answer = i_q;
        end
      end
      // RAM data holds the entry just below i_q, which is above zero.
      StBack: begin
        if (query_q < ram_rdata) begin
          step = i_q - IdxW'(1);
          if (step == '0) begin
            finish = 1'b1;
            answer = '0;
          end else begin
            nlo     = step - IdxW'(1);
            ram_re  = 1'b1;
            rd_addr = nlo[AddrW-1:0];
            i_d     = step;
          end
        end else begin
          finish = 1'b1;
          answer = i_q;
        end
      end
      StBin0: begin
        if (query_q <= ram_rdata) begin
          finish = 1'b1;
          answer = '0;
        end else begin
          step    = eff_n - IdxW'(1);
          ram_re  = 1'b1;
          rd_addr = step[AddrW-1:0];
          state_d = StBin1;
        end
      end
      // When bisection starts here the length is at least two, so its range is not empty.
      StBin1: begin
        if (query_q >= ram_rdata) begin
          finish = 1'b1;
          answer = eff_n;
        end else begin
          nhi     = eff_n - IdxW'(1);
          step    = nhi >> 1;
          lo_d    = '0;
          hi_d    = nhi;
          ram_re  = 1'b1;
          rd_addr = step[AddrW-1:0];
          i_d     = step;
          state_d = StBmid;
        end
      end
      StBmid: begin
        if (query_q <= ram_rdata) begin
          nhi = i_q;
        end else begin
          nlo = i_q + IdxW'(1);
        end
        lo_d = nlo;
        hi_d = nhi;
        if (nlo < nhi) begin
          step    = nlo + ((nhi - nlo) >> 1);
          ram_re  = 1'b1;
          rd_addr = step[AddrW-1:0];
          i_d     = step;
        end else begin
          finish = 1'b1;
          answer = nlo;
        end
      end
      StNear0: begin
        if (query_q >= ram_rdata) begin
          ram_re  = 1'b1;
          rd_addr = prev_q[AddrW-1:0];
          i_d     = prev_q;
          state_d = StFwd;
        end else begin
          step    = prev_q - IdxW'(1);
          ram_re  = 1'b1;
          rd_addr = step[AddrW-1:0];
          state_d = StNear1;
        end
      end
      StNear1: begin
        if (query_q <= ram_rdata) begin
          step    = prev_q - IdxW'(1);
          ram_re  = 1'b1;
          rd_addr = step[AddrW-1:0];
          i_d     = prev_q;
          state_d = StBack;
        end else begin
          finish = 1'b1;
          answer = prev_q;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (finish) begin
      state_d        = StIdle;
      prev_d         = answer;
      found_d        = answer;
      result_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      mode_q         <= ModeBin;
      len_q          <= MaxEntriesIdx;
      prev_q         <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      prev_q         <= prev_d;
      result_valid_q <= result_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgMode:   mode_q <= cfg_wdata_i[ModeW-1:0];
          CfgLength: len_q  <= cfg_wdata_i;
          default:   ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
    if (accept) begin
      query_q <= query_value_i;
    end
  end

  assign result_valid_o = result_valid_q;
  assign found_index_o  = found_q;

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a search in progress");

  // The spare mode repeats an answer given under an older length, so only
  // the table size bounds every result.
  a_result_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (found_index_o <= MaxEntriesIdx))
    else $error("found index beyond the table size");

  a_search_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindSearch)) |=> busy)
    else $error("search beat accepted but block not busy");

  a_load_is_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KindLoad)) |=> (!busy && !result_valid_o))
    else $error("load beat produced work or a result");

endmodule
